// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GMCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GMCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gmcp_pkg.sv -----
// ----------------------------------------------------------------------------
// gmcp_pkg
// Shared types and constants of the grid minimum-cost path block.
// ----------------------------------------------------------------------------
package gmcp_pkg;

  // Fixed field widths.
  localparam int GRID_W     = 5;
  localparam int COST_IN_W  = 10;
  localparam int PATH_W     = 18;

  localparam logic [PATH_W-1:0] PATH_MAX   = {PATH_W{1'b1}};
  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(16);

  // Parameter defaults.
  localparam int DEF_MAX_SIDE  = 16;
  localparam int DEF_COST_BITS = 10;

  // Neighbor directions, in relaxation order.
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // One entry of the search store.
  typedef struct packed {
    logic              reached;
    logic              settled;
    logic [PATH_W-1:0] best;
  } cell_state_t;

endpackage

// ----- rtl/gmcp_ram.sv -----
// ----------------------------------------------------------------------------
// gmcp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gmcp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/grid_min_cost_path.sv -----
// ----------------------------------------------------------------------------
// grid_min_cost_path
// Least-sum four-way path from the top-left to the bottom-right grid cell.
// ----------------------------------------------------------------------------
// Cell costs arrive one beat per cycle in row-major order; each beat, up to
// MAX_SIDE squared of them, is written straight into the cost RAM, so loading
// runs at one cell per cycle while cell_stall is low. The beat with last_cell
// set ends the load. If the number of cells loaded since the previous load
// ended differs from grid_size squared (grid_size 0 acts as 1, values above
// MAX_SIDE act as MAX_SIDE), one result beat reports load_error = 1 and
// path_cost = 0. Otherwise a Dijkstra search runs, and cell_stall stays high
// until its result has been placed in the output register. Both end cells
// count toward the sum, and every addition saturates at 262143. The search
// first clears the state RAM, one entry per cycle over N = side*side entries,
// and seeds the top-left entry with its cost. It then repeats rounds: a scan
// over all N entries through the single read port of the state RAM to find
// the least unsettled reached cell, a step to settle it, and for each of its
// neighbors inside the grid a read and, if the path improves, a write. The
// search ends with a scan that finds no cell left; the scan over the state
// RAM dominates. The result register frees the search from the consumer: a
// finished result waits there while new cells are loaded. Configuration
// writes are always ready and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_min_cost_path #(
  parameter int MAX_SIDE  = gmcp_pkg::DEF_MAX_SIDE,
  parameter int COST_BITS = gmcp_pkg::DEF_COST_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gmcp_pkg::GRID_W-1:0]  cfg_data,
  // Cell input channel.
  input  logic                         cell_valid,
  output logic                         cell_stall,
  input  logic [gmcp_pkg::COST_IN_W-1:0] cell_cost,
  input  logic                         last_cell,
  // Result output channel.
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [gmcp_pkg::PATH_W-1:0]  path_cost,
  output logic                         load_error
);

  import gmcp_pkg::*;

  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 2);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int ROW_W  = $clog2(MAX_SIDE);
  localparam int CIN_W  = (COST_BITS < COST_IN_W) ? COST_BITS : COST_IN_W;
  localparam int SUM_W  = ((COST_BITS > PATH_W) ? COST_BITS : PATH_W) + 1;
  localparam int ST_W   = $bits(cell_state_t);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_SEED   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_PICK   = 4'd4;
  localparam logic [3:0] S_NREAD  = 4'd5;
  localparam logic [3:0] S_NWRITE = 4'd6;
  localparam logic [3:0] S_FINAL  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  function automatic logic [PATH_W-1:0] sat_add(input logic [PATH_W-1:0] a,
                                                input logic [COST_BITS-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return (s > SUM_W'(PATH_MAX)) ? PATH_MAX : s[PATH_W-1:0];
  endfunction

  // Control registers.
  logic [3:0]        state;
  logic [GRID_W-1:0] grid_size;
  logic [CNT_W-1:0]  load_count;
  logic              err_flag;

  // Search registers.
  logic [SIDE_W-1:0] side_r;
  logic [CNT_W-1:0]  total_r;
  logic [CNT_W-1:0]  scan_idx;
  logic [ROW_W-1:0]  scan_row;
  logic [ROW_W-1:0]  scan_col;
  logic              eval_valid;
  logic [IDX_W-1:0]  eval_idx;
  logic [ROW_W-1:0]  eval_row;
  logic [ROW_W-1:0]  eval_col;
  logic              pick_found;
  logic [IDX_W-1:0]  pick_idx;
  logic [ROW_W-1:0]  pick_row;
  logic [ROW_W-1:0]  pick_col;
  logic [PATH_W-1:0] pick_best;
  logic [1:0]        dir;

  // RAM ports.
  logic                 cost_we;
  logic [IDX_W-1:0]     cost_waddr;
  logic [COST_BITS-1:0] cost_wdata;
  logic [IDX_W-1:0]     cost_raddr;
  logic [COST_BITS-1:0] cost_rdata;
  logic                 st_we;
  logic [IDX_W-1:0]     st_waddr;
  cell_state_t          st_wdata;
  logic [IDX_W-1:0]     st_raddr;
  logic [ST_W-1:0]      st_rdata_raw;
  cell_state_t          st_rd;

  // Combinational helpers.
  logic              cell_beat;
  logic [SIDE_W-1:0] side_cur;
  logic [CNT_W-1:0]  total_cur;
  logic [CNT_W-1:0]  count_next;
  logic              better;
  logic              n_ok;
  logic [IDX_W-1:0]  n_idx;
  logic [PATH_W-1:0] cand;
  logic              relax;
  logic              out_free;
  logic [ROW_W-1:0]  last_col;

  assign cfg_ready  = 1'b1;
  assign cell_stall = (state != S_IDLE);
  assign cell_beat  = cell_valid && !cell_stall;
  assign out_free   = !result_valid || !result_stall;
  assign st_rd      = cell_state_t'(st_rdata_raw);

  // Side in use and the cell count it calls for.
  always_comb begin
    if (grid_size == '0) begin
      side_cur = SIDE_W'(1);
    end else if (int'(grid_size) > MAX_SIDE) begin
      side_cur = SIDE_W'(MAX_SIDE);
    end else begin
      side_cur = SIDE_W'(grid_size);
    end
    total_cur  = CNT_W'(side_cur) * CNT_W'(side_cur);
    count_next = (load_count <= CNT_W'(CELLS)) ? load_count + 1'b1 : load_count;
  end

  // Scan compare: the first strictly smaller entry wins, so ties keep the
  // lowest index.
  assign better = eval_valid && st_rd.reached && !st_rd.settled &&
                  (!pick_found || st_rd.best < pick_best);

  // Neighbor of the settled cell in the current direction.
  always_comb begin
    case (dir)
      DIR_RIGHT: begin
        n_ok  = (SIDE_W'(pick_col) + 1'b1) < side_r;
        n_idx = pick_idx + 1'b1;
      end
      DIR_LEFT: begin
        n_ok  = (pick_col != '0);
        n_idx = pick_idx - 1'b1;
      end
      DIR_DOWN: begin
        n_ok  = (SIDE_W'(pick_row) + 1'b1) < side_r;
        n_idx = pick_idx + IDX_W'(side_r);
      end
      default: begin
        n_ok  = (pick_row != '0);
        n_idx = pick_idx - IDX_W'(side_r);
      end
    endcase
  end

  assign cand     = sat_add(pick_best, cost_rdata);
  assign relax    = !st_rd.reached || (cand < st_rd.best);
  assign last_col = ROW_W'(side_r - 1'b1);

  // Cost RAM: written while loading, read for the seed and for neighbors.
  assign cost_we    = cell_beat && (load_count < CNT_W'(CELLS));
  assign cost_waddr = load_count[IDX_W-1:0];
  assign cost_wdata = COST_BITS'(cell_cost[CIN_W-1:0]);
  assign cost_raddr = (state == S_NREAD) ? n_idx : '0;

  // State RAM port selection.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = '{reached: 1'b0, settled: 1'b0, best: PATH_MAX};
    st_raddr = '0;
    case (state)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = scan_idx[IDX_W-1:0];
      end
      S_SEED: begin
        st_we    = 1'b1;
        st_wdata = '{reached: 1'b1, settled: 1'b0, best: sat_add('0, cost_rdata)};
      end
      S_SCAN: begin
        st_raddr = scan_idx[IDX_W-1:0];
      end
      S_PICK: begin
        st_we    = pick_found;
        st_waddr = pick_idx;
        st_wdata = '{reached: 1'b1, settled: 1'b1, best: pick_best};
      end
      S_NREAD: begin
        st_raddr = n_idx;
      end
      S_NWRITE: begin
        st_we    = relax;
        st_waddr = n_idx;
        st_wdata = '{reached: 1'b1, settled: st_rd.settled, best: cand};
      end
      S_FINAL, S_OUT: begin
        st_raddr = IDX_W'(total_r - 1'b1);
      end
      default: begin
        st_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      grid_size    <= GRID_RESET;
      load_count   <= '0;
      result_valid <= 1'b0;
      err_flag     <= 1'b0;
      pick_found   <= 1'b0;
      eval_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        grid_size <= cfg_data;
      end
      // In S_OUT a taken beat is replaced by the new result below.
      if (result_valid && !result_stall && state != S_OUT) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cell_beat) begin
            if (last_cell) begin
              load_count <= '0;
              side_r     <= side_cur;
              total_r    <= total_cur;
              scan_idx   <= '0;
              err_flag   <= (count_next != total_cur);
              state      <= (count_next != total_cur) ? S_OUT : S_CLEAR;
            end else begin
              load_count <= count_next;
            end
          end
        end
        S_CLEAR: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == total_r - 1'b1) begin
            state <= S_SEED;
          end
        end
        S_SEED: begin
          scan_idx   <= '0;
          scan_row   <= '0;
          scan_col   <= '0;
          eval_valid <= 1'b0;
          pick_found <= 1'b0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          if (better) begin
            pick_found <= 1'b1;
            pick_idx   <= eval_idx;
            pick_row   <= eval_row;
            pick_col   <= eval_col;
            pick_best  <= st_rd.best;
          end
          eval_valid <= (scan_idx != total_r);
          eval_idx   <= scan_idx[IDX_W-1:0];
          eval_row   <= scan_row;
          eval_col   <= scan_col;
          scan_idx   <= scan_idx + 1'b1;
          if (scan_col == last_col) begin
            scan_col <= '0;
            scan_row <= scan_row + 1'b1;
          end else begin
            scan_col <= scan_col + 1'b1;
          end
          if (scan_idx == total_r) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          dir   <= DIR_RIGHT;
          state <= pick_found ? S_NREAD : S_FINAL;
        end
        S_NREAD, S_NWRITE: begin
          if (state == S_NREAD && n_ok) begin
            state <= S_NWRITE;
          end else if (dir == DIR_UP) begin
            scan_idx   <= '0;
            scan_row   <= '0;
            scan_col   <= '0;
            eval_valid <= 1'b0;
            pick_found <= 1'b0;
            state      <= S_SCAN;
          end else begin
            dir   <= dir + 1'b1;
            state <= S_NREAD;
          end
        end
        S_FINAL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            path_cost    <= err_flag ? '0 : st_rd.best;
            load_error   <= err_flag;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  gmcp_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (CELLS)
  ) u_cost_ram (
    .clk   (clk),
    .we    (cost_we),
    .waddr (cost_waddr),
    .wdata (cost_wdata),
    .raddr (cost_raddr),
    .rdata (cost_rdata)
  );

  gmcp_ram #(
    .WIDTH (ST_W),
    .DEPTH (CELLS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (ST_W'(st_wdata)),
    .raddr (st_raddr),
    .rdata (st_rdata_raw)
  );

  // A final cell always starts a search or an error report.
  `GMCP_ASSERT_NEXT(a_last_leaves_idle, cell_beat && last_cell, state != S_IDLE, "last cell did not start work")
  // An error result carries a zero sum.
  `GMCP_ASSERT_NOW(a_error_zero_sum, result_valid && load_error, path_cost == '0, "error result with nonzero sum")
  // Relaxation only touches cells of the grid in use.
  `GMCP_ASSERT_NOW(a_relax_in_grid, state == S_NWRITE, CNT_W'(n_idx) < total_r, "neighbor outside grid")
  // A settled pick lies inside the grid in use.
  `GMCP_ASSERT_NOW(a_pick_in_grid, state == S_PICK && pick_found, CNT_W'(pick_idx) < total_r, "pick outside grid")

endmodule
